/* rtl/aesgcm_pkg.sv */
// ---------------------------------------------------------------------------
// aesgcm_pkg
// Shared types, codes and AES helper functions for the AES-128 GCM core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package aesgcm_pkg;

   localparam int NUM_ROUNDS = 10;
   localparam int RND_W = $clog2(NUM_ROUNDS + 1);
   localparam int GH_BITS = 4;                       // GHASH bits per cycle
   localparam int GH_STEPS = 128 / GH_BITS;
   localparam int GH_CNT_W = $clog2(GH_STEPS);

   typedef enum logic [1:0] {
      REQ_AAD    = 2'd0,
      REQ_TEXT   = 2'd1,
      REQ_FINISH = 2'd2,
      REQ_BAD    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      RSP_CIPHER = 2'd0,
      RSP_TAG    = 2'd1,
      RSP_ERROR  = 2'd2,
      RSP_NONE   = 2'd3
   } rsp_kind_type;

   typedef enum logic [1:0] {
      AES_SRC_ZERO = 2'd0,
      AES_SRC_J0   = 2'd1,
      AES_SRC_CTR  = 2'd2,
      AES_SRC_NONE = 2'd3
   } aes_src_type;

   typedef enum logic [1:0] {
      GH_SRC_BLOCK = 2'd0,
      GH_SRC_CT    = 2'd1,
      GH_SRC_LEN   = 2'd2,
      GH_SRC_NONE  = 2'd3
   } gh_src_type;

   typedef enum logic [2:0] {
      CSR_KEY_HIGH = 3'd0,
      CSR_KEY_LOW  = 3'd1,
      CSR_IV_HIGH  = 3'd2,
      CSR_IV_LOW   = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic         latch_item;
      logic         msg_init;
      logic         aes_go;
      aes_src_type  aes_sel;
      logic         save_h;
      logic         save_mask;
      logic         ctr_inc;
      logic         aad_add;
      logic         text_add;
      logic         ct_save;
      logic         gh_go;
      gh_src_type   gh_sel;
      logic         out_load;
      rsp_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic [4:0]   n;
      logic         short_blk;
      logic         ctr_max;
      logic         aad_ovf;
      logic         aes_busy;
      logic         gh_busy;
      logic         out_free;
   } status_type;

   localparam logic [7:0] SBOX [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // next round key from the current one
   function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
      logic [31:0] t;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      t = {rk[23:0], rk[31:24]};
      t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
      t = t ^ {rcon, 24'd0};
      w0 = rk[127:96] ^ t;
      w1 = rk[95:64] ^ w0;
      w2 = rk[63:32] ^ w1;
      w3 = rk[31:0] ^ w2;
      key_next = {w0, w1, w2, w3};
   endfunction

   // SubBytes, ShiftRows and (unless last) MixColumns; byte 0 in the top bits
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] all;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) begin
         b[i] = SBOX[s[127 - 8 * i -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[4 * c + i] = b[4 * ((c + i) % 4) + i];
         end
      end
      for (int c = 0; c < 4; c++) begin
         all = t[4 * c] ^ t[4 * c + 1] ^ t[4 * c + 2] ^ t[4 * c + 3];
         if (last) begin
            for (int i = 0; i < 4; i++) begin
               r[127 - 8 * (4 * c + i) -: 8] = t[4 * c + i];
            end
         end else begin
            for (int i = 0; i < 4; i++) begin
               r[127 - 8 * (4 * c + i) -: 8] = t[4 * c + i] ^ all
                  ^ xtime(t[4 * c + i] ^ t[4 * c + ((i + 1) % 4)]);
            end
         end
      end
      aes_round = r;
   endfunction

endpackage
`default_nettype wire

/* rtl/aesgcm_ctrl.sv */
// ---------------------------------------------------------------------------
// aesgcm_ctrl
// Sequencer: checks each item, runs message start, AES and GHASH passes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aesgcm_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire aesgcm_pkg::status_type stat,
   output aesgcm_pkg::cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_START, S_AES_H, S_WAIT_H, S_AES_J0, S_WAIT_J0,
      S_DISPATCH, S_AES_CTR, S_WAIT_CTR, S_GHASH, S_WAIT_GH, S_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_AAD      = 3'd1,
      PH_AAD_END  = 3'd2,
      PH_TEXT     = 3'd3,
      PH_TEXT_END = 3'd4
   } phase_type;

   state_type                 state_ff, state_in;
   phase_type                 phase_ff, phase_in;
   aesgcm_pkg::rsp_kind_type  kind_ff, kind_in;
   phase_type                 ph;
   logic                      err;

   assign req_tready = (state_ff == S_IDLE);
   assign ph = (phase_ff == PH_IDLE) ? PH_AAD : phase_ff;

   always_comb begin
      err = 1'b0;
      case (stat.kind)
         aesgcm_pkg::REQ_FINISH: err = 1'b0;
         aesgcm_pkg::REQ_AAD:
            err = (stat.n == 5'd0) || (stat.n > 5'd16) || (ph != PH_AAD)
               || ((phase_ff != PH_IDLE) && stat.aad_ovf);
         aesgcm_pkg::REQ_TEXT:
            err = (stat.n == 5'd0) || (stat.n > 5'd16) || (ph == PH_TEXT_END)
               || ((phase_ff != PH_IDLE) && stat.ctr_max);
         default: err = 1'b1;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.aes_sel  = aesgcm_pkg::AES_SRC_NONE;
      cmd.gh_sel   = aesgcm_pkg::GH_SRC_NONE;
      cmd.out_kind = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_item = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (err) begin
               kind_in  = aesgcm_pkg::RSP_ERROR;
               state_in = S_EMIT;
            end else if (phase_ff == PH_IDLE) begin
               state_in = S_START;
            end else begin
               state_in = S_DISPATCH;
            end
         end
         S_START: begin
            cmd.msg_init = 1'b1;
            phase_in = PH_AAD;
            state_in = S_AES_H;
         end
         S_AES_H: begin
            cmd.aes_go  = 1'b1;
            cmd.aes_sel = aesgcm_pkg::AES_SRC_ZERO;
            state_in = S_WAIT_H;
         end
         S_WAIT_H: begin
            if (!stat.aes_busy) begin
               cmd.save_h = 1'b1;
               state_in = S_AES_J0;
            end
         end
         S_AES_J0: begin
            cmd.aes_go  = 1'b1;
            cmd.aes_sel = aesgcm_pkg::AES_SRC_J0;
            state_in = S_WAIT_J0;
         end
         S_WAIT_J0: begin
            if (!stat.aes_busy) begin
               cmd.save_mask = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.kind)
               aesgcm_pkg::REQ_AAD: begin
                  cmd.aad_add = 1'b1;
                  phase_in = stat.short_blk ? PH_AAD_END : PH_AAD;
                  state_in = S_GHASH;
               end
               aesgcm_pkg::REQ_TEXT: begin
                  cmd.ctr_inc  = 1'b1;
                  cmd.text_add = 1'b1;
                  phase_in = stat.short_blk ? PH_TEXT_END : PH_TEXT;
                  state_in = S_AES_CTR;
               end
               aesgcm_pkg::REQ_FINISH: begin
                  phase_in = PH_IDLE;
                  state_in = S_GHASH;
               end
               default: begin
                  kind_in  = aesgcm_pkg::RSP_ERROR;
                  state_in = S_EMIT;
               end
            endcase
         end
         S_AES_CTR: begin
            cmd.aes_go  = 1'b1;
            cmd.aes_sel = aesgcm_pkg::AES_SRC_CTR;
            state_in = S_WAIT_CTR;
         end
         S_WAIT_CTR: begin
            if (!stat.aes_busy) begin
               cmd.ct_save = 1'b1;
               state_in = S_GHASH;
            end
         end
         S_GHASH: begin
            cmd.gh_go = 1'b1;
            case (stat.kind)
               aesgcm_pkg::REQ_AAD:  cmd.gh_sel = aesgcm_pkg::GH_SRC_BLOCK;
               aesgcm_pkg::REQ_TEXT: cmd.gh_sel = aesgcm_pkg::GH_SRC_CT;
               default:              cmd.gh_sel = aesgcm_pkg::GH_SRC_LEN;
            endcase
            state_in = S_WAIT_GH;
         end
         S_WAIT_GH: begin
            if (!stat.gh_busy) begin
               case (stat.kind)
                  aesgcm_pkg::REQ_AAD: state_in = S_IDLE;
                  aesgcm_pkg::REQ_TEXT: begin
                     kind_in  = aesgcm_pkg::RSP_CIPHER;
                     state_in = S_EMIT;
                  end
                  default: begin
                     kind_in  = aesgcm_pkg::RSP_TAG;
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_IDLE;
         kind_ff  <= aesgcm_pkg::RSP_ERROR;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/aesgcm_dp.sv */
// ---------------------------------------------------------------------------
// aesgcm_dp
// Datapath: config registers, iterative AES round unit with on-the-fly key
// schedule, 4-bit-per-cycle GHASH multiplier, message state, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aesgcm_dp (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_valid,
   input  wire  [2:0]              csr_index,
   input  wire  [63:0]             csr_data,
   input  wire  [1:0]              req_tuser,
   input  wire  [135:0]            req_tdata,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [1:0]              rsp_tuser,
   output logic [135:0]            rsp_tdata,
   input  wire aesgcm_pkg::cmd_type cmd,
   output aesgcm_pkg::status_type  stat
);

   logic [63:0]  key_hi_ff, key_lo_ff, iv_hi_ff;
   logic [31:0]  iv_lo_ff;
   logic [127:0] msg_key_ff;
   logic [95:0]  msg_iv_ff;
   logic [1:0]   kind_ff;
   logic [4:0]   n_ff;
   logic [127:0] blk_ff, mask_ff, mask_in;
   logic [127:0] h_ff, tmask_ff, ct_ff, acc_ff;
   logic [31:0]  ctr_ff;
   logic [63:0]  aad_ff, text_ff;
   logic [64:0]  aad_sum;
   logic [63:0]  text_sum;
   // AES unit
   logic [127:0] s_ff, rk_ff, rk_nx, aes_src;
   logic [7:0]   rcon_ff;
   logic [aesgcm_pkg::RND_W-1:0] rnd_ff;
   logic         aes_busy_ff;
   // GHASH unit
   logic [127:0] ga_ff, gz_ff, gv_ff, gh_src;
   logic [127:0] ga_nx, gz_nx, gv_nx;
   logic [aesgcm_pkg::GH_CNT_W-1:0] gcnt_ff;
   logic         gh_busy_ff;
   // result register
   logic         out_valid_ff;
   logic [1:0]   out_kind_ff;
   logic [127:0] out_data_ff;
   logic [4:0]   out_n_ff;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         mask_in[127 - 8 * i -: 8] = (5'(i) < req_tdata[132:128]) ? 8'hff : 8'h00;
      end
   end

   assign aad_sum  = {1'b0, aad_ff} + {57'd0, n_ff, 3'd0};
   assign text_sum = text_ff + {56'd0, n_ff, 3'd0};

   assign stat.kind      = aesgcm_pkg::req_kind_type'(kind_ff);
   assign stat.n         = n_ff;
   assign stat.short_blk = (n_ff < 5'd16);
   assign stat.ctr_max   = (ctr_ff == 32'hffff_ffff);
   assign stat.aad_ovf   = aad_sum[64];
   assign stat.aes_busy  = aes_busy_ff;
   assign stat.gh_busy   = gh_busy_ff;
   assign stat.out_free  = !out_valid_ff || rsp_tready;

   always_comb begin
      case (cmd.aes_sel)
         aesgcm_pkg::AES_SRC_J0:  aes_src = {msg_iv_ff, 32'd1};
         aesgcm_pkg::AES_SRC_CTR: aes_src = {msg_iv_ff, ctr_ff};
         default:                 aes_src = '0;
      endcase
      case (cmd.gh_sel)
         aesgcm_pkg::GH_SRC_BLOCK: gh_src = blk_ff;
         aesgcm_pkg::GH_SRC_CT:    gh_src = ct_ff;
         aesgcm_pkg::GH_SRC_LEN:   gh_src = {aad_ff, text_ff};
         default:                  gh_src = '0;
      endcase
   end

   assign rk_nx = aesgcm_pkg::key_next(rk_ff, rcon_ff);

   // GF(2^128) multiply, GCM bit order, a few bits per cycle
   always_comb begin
      ga_nx = ga_ff;
      gz_nx = gz_ff;
      gv_nx = gv_ff;
      for (int i = 0; i < aesgcm_pkg::GH_BITS; i++) begin
         if (ga_nx[127]) begin
            gz_nx = gz_nx ^ gv_nx;
         end
         ga_nx = {ga_nx[126:0], 1'b0};
         gv_nx = {1'b0, gv_nx[127:1]} ^ (gv_nx[0] ? {8'he1, 120'd0} : 128'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff    <= '0;
         key_lo_ff    <= '0;
         iv_hi_ff     <= '0;
         iv_lo_ff     <= '0;
         acc_ff       <= '0;
         ctr_ff       <= '0;
         aad_ff       <= '0;
         text_ff      <= '0;
         aes_busy_ff  <= 1'b0;
         gh_busy_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               aesgcm_pkg::CSR_KEY_HIGH: key_hi_ff <= csr_data;
               aesgcm_pkg::CSR_KEY_LOW:  key_lo_ff <= csr_data;
               aesgcm_pkg::CSR_IV_HIGH:  iv_hi_ff  <= csr_data;
               aesgcm_pkg::CSR_IV_LOW:   iv_lo_ff  <= csr_data[31:0];
               default: ;
            endcase
         end
         if (cmd.msg_init) begin
            acc_ff  <= '0;
            ctr_ff  <= 32'd1;
            aad_ff  <= '0;
            text_ff <= '0;
         end
         if (cmd.ctr_inc) begin
            ctr_ff <= ctr_ff + 32'd1;
         end
         if (cmd.aad_add) begin
            aad_ff <= aad_sum[63:0];
         end
         if (cmd.text_add) begin
            text_ff <= text_sum;
         end
         if (cmd.aes_go) begin
            aes_busy_ff <= 1'b1;
         end else if (aes_busy_ff && (rnd_ff == aesgcm_pkg::RND_W'(aesgcm_pkg::NUM_ROUNDS))) begin
            aes_busy_ff <= 1'b0;
         end
         if (cmd.gh_go) begin
            gh_busy_ff <= 1'b1;
         end else if (gh_busy_ff && (gcnt_ff == aesgcm_pkg::GH_CNT_W'(aesgcm_pkg::GH_STEPS - 1))) begin
            gh_busy_ff <= 1'b0;
            acc_ff     <= gz_nx;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         kind_ff <= req_tuser;
         n_ff    <= req_tdata[132:128];
         mask_ff <= mask_in;
         blk_ff  <= {req_tdata[63:0], req_tdata[127:64]} & mask_in;
      end
      if (cmd.msg_init) begin
         msg_key_ff <= {key_hi_ff, key_lo_ff};
         msg_iv_ff  <= {iv_hi_ff, iv_lo_ff};
      end
      if (cmd.save_h) begin
         h_ff <= s_ff;
      end
      if (cmd.save_mask) begin
         tmask_ff <= s_ff;
      end
      if (cmd.ct_save) begin
         ct_ff <= (s_ff ^ blk_ff) & mask_ff;
      end
      if (cmd.aes_go) begin
         s_ff    <= aes_src ^ msg_key_ff;
         rk_ff   <= msg_key_ff;
         rcon_ff <= 8'h01;
         rnd_ff  <= aesgcm_pkg::RND_W'(1);
      end else if (aes_busy_ff) begin
         s_ff    <= aesgcm_pkg::aes_round(s_ff,
                       rnd_ff == aesgcm_pkg::RND_W'(aesgcm_pkg::NUM_ROUNDS)) ^ rk_nx;
         rk_ff   <= rk_nx;
         rcon_ff <= aesgcm_pkg::xtime(rcon_ff);
         rnd_ff  <= rnd_ff + aesgcm_pkg::RND_W'(1);
      end
      if (cmd.gh_go) begin
         ga_ff   <= acc_ff ^ gh_src;
         gz_ff   <= '0;
         gv_ff   <= h_ff;
         gcnt_ff <= '0;
      end else if (gh_busy_ff) begin
         ga_ff   <= ga_nx;
         gz_ff   <= gz_nx;
         gv_ff   <= gv_nx;
         gcnt_ff <= gcnt_ff + aesgcm_pkg::GH_CNT_W'(1);
      end
      if (cmd.out_load) begin
         out_kind_ff <= cmd.out_kind;
         case (cmd.out_kind)
            aesgcm_pkg::RSP_CIPHER: begin
               out_data_ff <= ct_ff;
               out_n_ff    <= n_ff;
            end
            aesgcm_pkg::RSP_TAG: begin
               out_data_ff <= acc_ff ^ tmask_ff;
               out_n_ff    <= 5'd16;
            end
            default: begin
               out_data_ff <= '0;
               out_n_ff    <= 5'd0;
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {3'd0, out_n_ff, out_data_ff[63:0], out_data_ff[127:64]};

endmodule
`default_nettype wire

/* rtl/aes128_gcm_encrypt_core.sv */
// ---------------------------------------------------------------------------
// aes128_gcm_encrypt_core
// AES-128 GCM encryption with a 96-bit IV: AAD, plaintext and finish items.
// ---------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tuser: kind; tdata: block, byte count
//  rsp     | out | rsp_tvalid/tready   | tuser: result kind; tdata: data, bytes
//  csr     | in  | csr_valid/ready     | csr_index, csr_data
//
//  AAD item: one GHASH pass at 4 bits per cycle, then ready for the next item.
//  Plaintext item: an AES pass, one round per cycle, then a GHASH pass.
//  The first item of a message computes E(0) and E(J0) before that.
//  Errors go from the item check to the result register. One item in flight at a time.
//  reset is synchronous; a held result stalls the sequencer until taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aes128_gcm_encrypt_core (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [1:0]   req_tuser,   // req_type
   input  wire  [135:0] req_tdata,   // block_high, block_low, byte_count
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [1:0]   rsp_tuser,   // result_kind
   output logic [135:0] rsp_tdata,   // data_high, data_low, valid_bytes
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [2:0]   csr_index,
   input  wire  [63:0]  csr_data
);

   aesgcm_pkg::cmd_type    cmd;
   aesgcm_pkg::status_type stat;

   assign csr_ready = 1'b1;

   aesgcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   aesgcm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
`default_nettype wire

/* rtl/aesgcm_checker.sv */
// ---------------------------------------------------------------------------
// aesgcm_checker
// Port-level checks on the result channel of the GCM core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aesgcm_checker (
   input wire         clock,
   input wire         reset,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [1:0]   rsp_tuser,
   input wire [135:0] rsp_tdata
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == aesgcm_pkg::RSP_ERROR) |-> (rsp_tdata == '0))
      else $error("error item carries data");

   a_tag_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == aesgcm_pkg::RSP_TAG) |-> (rsp_tdata[132:128] == 5'd16))
      else $error("tag item without 16 bytes");

   a_ct_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == aesgcm_pkg::RSP_CIPHER)
      |-> (rsp_tdata[132:128] != 5'd0) && (rsp_tdata[132:128] <= 5'd16))
      else $error("ciphertext byte count out of range");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind aes128_gcm_encrypt_core aesgcm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
